// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BNC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BNC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BNC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BNC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== src/bnc_pkg.sv =====
// ----------------------------------------------------------------------------
// bnc_pkg
// shared constants, types and helpers of the bracket nesting checker
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int unsigned STACK_DEPTH = 4096;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned POS_W       = 16;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    KIND_ROUND  = 3'd0,
    KIND_SQUARE = 3'd1,
    KIND_CURLY  = 3'd2,
    KIND_ANGLE  = 3'd3,
    KIND_STAR   = 3'd4
  } kind_e;

  typedef struct packed {
    logic              balanced;
    logic [POS_W-1:0]  position;
    logic              overflow;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    kind_e             wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v == {POS_W{1'b1}}) ? v : v + POS_W'(1);
  endfunction

endpackage

// ===== src/bnc_stack_ram.sv =====
// ----------------------------------------------------------------------------
// bnc_stack_ram
// bracket stack storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bnc_stack_ram (
  input  logic               clk_i,
  input  bnc_pkg::ram_req_t  req_i,
  output bnc_pkg::kind_e     rd_data_o
);

  bnc_pkg::kind_e mem [bnc_pkg::STACK_DEPTH];
  bnc_pkg::kind_e rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/bnc_core.sv =====
// ----------------------------------------------------------------------------
// bnc_core
// token decode, top-of-stack cache and line state of the nesting checker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bnc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_acc_i,
  input  logic [7:0]         symbol_i,
  input  logic               has_symbol_i,
  input  logic               last_i,
  output logic               res_valid_o,
  output bnc_pkg::res_t      res_o,
  output bnc_pkg::ram_req_t  ram_req_o,
  input  bnc_pkg::kind_e     rd_data_i
);

  logic [bnc_pkg::DEPTH_W-1:0] depth_q, depth_d;
  bnc_pkg::kind_e              top_q, top_d;
  logic [bnc_pkg::POS_W-1:0]   cnt_q, cnt_d;
  logic [bnc_pkg::POS_W-1:0]   cnt_inc;
  logic [bnc_pkg::POS_W-1:0]   fpos_q, fpos_d;
  logic                        pend_p_q, pend_p_d;
  logic                        pend_s_q, pend_s_d;
  logic                        failed_q, failed_d;
  logic                        ovf_q, ovf_d;
  logic                        fwd_q;
  bnc_pkg::kind_e              fwd_data_q;
  bnc_pkg::kind_e              sec;
  logic                        full;
  logic                        tok_new;
  logic                        push_en, pop_en, mod_en;
  bnc_pkg::kind_e              push_kind;
  logic                        close_en;
  bnc_pkg::kind_e              close_kind;
  logic [bnc_pkg::DEPTH_W-1:0] depth_rd;

  assign sec     = fwd_q ? fwd_data_q : rd_data_i;
  assign full    = (depth_q == bnc_pkg::DEPTH_W'(bnc_pkg::STACK_DEPTH));
  assign cnt_inc = bnc_pkg::sat_inc(cnt_q);

  // token decode, at most one stack operation per item
  always_comb begin
    cnt_d      = cnt_q;
    fpos_d     = fpos_q;
    pend_p_d   = pend_p_q;
    pend_s_d   = pend_s_q;
    failed_d   = failed_q;
    ovf_d      = ovf_q;
    tok_new    = 1'b0;
    push_en    = 1'b0;
    pop_en     = 1'b0;
    mod_en     = 1'b0;
    push_kind  = bnc_pkg::KIND_ROUND;
    close_en   = 1'b0;
    close_kind = bnc_pkg::KIND_ROUND;

    if (item_acc_i && has_symbol_i && !failed_q) begin
      tok_new = 1'b1;
      if (pend_p_q) begin
        // tentative round bracket already sits on top
        pend_p_d = 1'b0;
        if (symbol_i == bnc_pkg::CH_STAR) begin
          mod_en  = 1'b1;
          tok_new = 1'b0;
        end
      end else if (pend_s_q) begin
        pend_s_d = 1'b0;
        if (symbol_i == bnc_pkg::CH_RPAREN) begin
          tok_new = 1'b0;
          if (depth_q == '0 || top_q != bnc_pkg::KIND_STAR) begin
            failed_d = 1'b1;
            fpos_d   = cnt_q;
            ovf_d    = 1'b0;
          end else begin
            pop_en = 1'b1;
          end
        end
      end

      if (tok_new) begin
        cnt_d = cnt_inc;
        case (symbol_i)
          bnc_pkg::CH_LPAREN: begin
            push_en   = 1'b1;
            push_kind = bnc_pkg::KIND_ROUND;
            pend_p_d  = 1'b1;
          end
          bnc_pkg::CH_STAR: begin
            pend_s_d = 1'b1;
          end
          bnc_pkg::CH_LBRACK: begin
            push_en   = 1'b1;
            push_kind = bnc_pkg::KIND_SQUARE;
          end
          bnc_pkg::CH_LBRACE: begin
            push_en   = 1'b1;
            push_kind = bnc_pkg::KIND_CURLY;
          end
          bnc_pkg::CH_LT: begin
            push_en   = 1'b1;
            push_kind = bnc_pkg::KIND_ANGLE;
          end
          bnc_pkg::CH_RPAREN: begin
            close_en   = 1'b1;
            close_kind = bnc_pkg::KIND_ROUND;
          end
          bnc_pkg::CH_RBRACK: begin
            close_en   = 1'b1;
            close_kind = bnc_pkg::KIND_SQUARE;
          end
          bnc_pkg::CH_RBRACE: begin
            close_en   = 1'b1;
            close_kind = bnc_pkg::KIND_CURLY;
          end
          bnc_pkg::CH_GT: begin
            close_en   = 1'b1;
            close_kind = bnc_pkg::KIND_ANGLE;
          end
          default: begin
          end
        endcase

        if (push_en && full) begin
          push_en  = 1'b0;
          pend_p_d = 1'b0;
          failed_d = 1'b1;
          fpos_d   = cnt_inc;
          ovf_d    = 1'b1;
        end
        if (close_en) begin
          if (depth_q == '0 || top_q != close_kind) begin
            failed_d = 1'b1;
            fpos_d   = cnt_inc;
            ovf_d    = 1'b0;
          end else begin
            pop_en = 1'b1;
          end
        end
      end
    end
  end

  // stack pointer and top-of-stack cache
  always_comb begin
    depth_d = depth_q;
    top_d   = top_q;
    if (push_en) begin
      depth_d = depth_q + bnc_pkg::DEPTH_W'(1);
      top_d   = push_kind;
    end else if (pop_en) begin
      depth_d = depth_q - bnc_pkg::DEPTH_W'(1);
      top_d   = sec;
    end else if (mod_en) begin
      top_d = bnc_pkg::KIND_STAR;
    end
  end

  assign depth_rd          = depth_d - bnc_pkg::DEPTH_W'(2);
  assign ram_req_o.wr_en   = push_en && (depth_q != '0);
  assign ram_req_o.wr_addr = depth_rd[bnc_pkg::ADDR_W-1:0];
  assign ram_req_o.wr_data = top_q;
  assign ram_req_o.rd_addr = depth_rd[bnc_pkg::ADDR_W-1:0];

  // line end result
  always_comb begin
    res_valid_o = item_acc_i && last_i;
    if (failed_d) begin
      res_o.balanced = 1'b0;
      res_o.position = fpos_d;
      res_o.overflow = ovf_d;
    end else if (depth_d != '0) begin
      res_o.balanced = 1'b0;
      res_o.position = bnc_pkg::sat_inc(cnt_d);
      res_o.overflow = 1'b0;
    end else begin
      res_o.balanced = 1'b1;
      res_o.position = '0;
      res_o.overflow = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      cnt_q    <= '0;
      fpos_q   <= '0;
      pend_p_q <= 1'b0;
      pend_s_q <= 1'b0;
      failed_q <= 1'b0;
      ovf_q    <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (item_acc_i && last_i) begin
      depth_q  <= '0;
      cnt_q    <= '0;
      fpos_q   <= '0;
      pend_p_q <= 1'b0;
      pend_s_q <= 1'b0;
      failed_q <= 1'b0;
      ovf_q    <= 1'b0;
      fwd_q    <= push_en;
    end else begin
      depth_q  <= depth_d;
      cnt_q    <= cnt_d;
      fpos_q   <= fpos_d;
      pend_p_q <= pend_p_d;
      pend_s_q <= pend_s_d;
      failed_q <= failed_d;
      ovf_q    <= ovf_d;
      fwd_q    <= push_en;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    fwd_data_q <= top_q;
  end

  `BNC_ASSERT_NEVER(a_depth_max, clk_i, rst_ni, depth_q > bnc_pkg::DEPTH_W'(bnc_pkg::STACK_DEPTH), "stack depth beyond capacity")
  `BNC_ASSERT(a_pend_on_stack, clk_i, rst_ni, pend_p_q |-> depth_q != '0, "pending paren not on stack")
  `BNC_ASSERT_NEVER(a_pend_both, clk_i, rst_ni, pend_p_q && pend_s_q, "two pending characters")
  `BNC_ASSERT(a_fail_no_pend, clk_i, rst_ni, failed_q |-> !pend_p_q && !pend_s_q, "pending after failure")

endmodule

// ===== src/bnc_out_buf.sv =====
// ----------------------------------------------------------------------------
// bnc_out_buf
// result output register with one skid entry
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bnc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  bnc_pkg::res_t  res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bnc_pkg::res_t  out_o
);

  logic          out_valid_q;
  logic          skid_valid_q;
  bnc_pkg::res_t out_q;
  bnc_pkg::res_t skid_q;
  logic          load_out;

  assign load_out = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BNC_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid entry without output")
  `BNC_ASSERT(a_skid_on_stall, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i), "skid filled while output free")
  `BNC_ASSERT_NEVER(a_no_res_when_full, clk_i, rst_ni, skid_valid_q && res_valid_i, "item result lost")

endmodule

// ===== src/bracket_nesting_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_nesting_checker
// checks bracket nesting of a text line, one character per item
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry symbol_i, has_symbol_i and
// last_i; an item is taken on a clock edge with valid high and stall low.
// output channel: out_valid_o / out_stall_i carry balanced_o, position_o and
// overflow_o; one result per line, for the item with last_i set.
// throughput: one item per cycle while in_stall_o is low; the stack is kept in
// a memory with one write and one read port plus a top-of-stack register, so
// every character does at most one push, pop or top update in its own cycle.
// the result is registered in the output or skid register of the output stage.
// the output stage holds one result and one skid entry; in_stall_o rises
// only when both are full, i.e. after two results wait on a stalled receiver.
// reset clears the stack pointer, counters and output valids at once; the
// stack memory is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module bracket_nesting_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                symbol_i,
  input  logic                      has_symbol_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      balanced_o,
  output logic [bnc_pkg::POS_W-1:0] position_o,
  output logic                      overflow_o
);

  logic              item_acc;
  logic              res_valid;
  bnc_pkg::res_t     res;
  bnc_pkg::res_t     out_res;
  bnc_pkg::ram_req_t ram_req;
  bnc_pkg::kind_e    rd_data;
  logic              buf_full;

  assign in_stall_o = buf_full;
  assign item_acc   = in_valid_i && !buf_full;

  bnc_stack_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  bnc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_acc_i   (item_acc),
    .symbol_i     (symbol_i),
    .has_symbol_i (has_symbol_i),
    .last_i       (last_i),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .ram_req_o    (ram_req),
    .rd_data_i    (rd_data)
  );

  bnc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign balanced_o = out_res.balanced;
  assign position_o = out_res.position;
  assign overflow_o = out_res.overflow;

endmodule
